// ===== rtl/core/pfifo_pkg.sv =====
// shared types and constants of the prebuffered ring fifo
package pfifo_pkg;

  // ring geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = ADDR_W + 1;
  localparam int PREBUF_W = 6;
  localparam int CMP_W  = (FILL_W > PREBUF_W) ? FILL_W : PREBUF_W;

  // command queue between front and back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0]          MAX_BYTES    = 4'd8;
  localparam logic [PREBUF_W-1:0] PREBUF_RESET = 6'd2;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STOPPED     = 3'd1,
    ST_NOT_READY   = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_NO_READ_POS = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  nbytes;
    logic [31:0] stream_id;
    logic [31:0] user_tag;
  } entry_t;

  typedef struct packed {
    kind_t  kind;
    entry_t entry;
  } cmd_t;

  typedef struct packed {
    logic                done;
    status_t             status;
    logic                data_valid;
    entry_t              entry;
    logic [PREBUF_W-1:0] fill_level;
  } res_t;

endpackage

// ===== rtl/core/pfifo_front.sv =====
// front end: takes command beats, normalises write payloads, feeds the queue
module pfifo_front (
  input  logic             start,
  input  logic [1:0]       kind,
  input  logic [63:0]      payload,
  input  logic [3:0]       payload_bytes,
  input  logic [31:0]      stream_id,
  input  logic [31:0]      user_tag,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output pfifo_pkg::cmd_t  cmd
);
  import pfifo_pkg::*;

  logic [3:0] nb;

  // handshake towards the command source
  assign busy = q_full;
  assign push = start & ~q_full;

  // clamp the byte count and clear bytes above it
  always_comb begin
    nb = (payload_bytes > MAX_BYTES) ? MAX_BYTES : payload_bytes;
    cmd.kind = kind_t'(kind);
    cmd.entry.nbytes = nb;
    cmd.entry.stream_id = stream_id;
    cmd.entry.user_tag = user_tag;
    for (int i = 0; i < 8; i++) begin
      cmd.entry.payload[8*i +: 8] = (4'(i) < nb) ? payload[8*i +: 8] : 8'h00;
    end
  end

endmodule

// ===== rtl/core/pfifo_queue.sv =====
// short command queue decoupling the front end from the back end
module pfifo_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfifo_pkg::cmd_t push_cmd,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop,
  output pfifo_pkg::cmd_t pop_cmd
);
  import pfifo_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_pop    = pop & pop_valid;

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pfifo_back.sv =====
// back end: ring state, prebuffer gate, entry store and result register
module pfifo_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  pfifo_pkg::cmd_t                cmd,
  input  logic [pfifo_pkg::PREBUF_W-1:0] prebuffer_count,
  output logic                           pop,
  output pfifo_pkg::res_t                res
);
  import pfifo_pkg::*;

  // entry store
  entry_t mem [DEPTH];
  entry_t rdata;

  // ring state
  logic [ADDR_W-1:0] write_index, write_index_next;
  logic [ADDR_W-1:0] read_index, read_index_next;
  logic              read_index_valid, read_index_valid_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic              drain_phase, drain_phase_next;
  logic              stopped, stopped_next;

  // result register
  logic                done;
  status_t             status;
  logic                data_valid;
  logic [PREBUF_W-1:0] fill_level;

  status_t           st;
  logic              hit;
  logic              mem_we;
  logic [FILL_W-1:0] fill_inc;

  assign pop = cmd_valid;
  assign fill_inc = fill_count + 1'b1;

  // command execution
  always_comb begin
    write_index_next      = write_index;
    read_index_next       = read_index;
    read_index_valid_next = read_index_valid;
    fill_count_next       = fill_count;
    drain_phase_next      = drain_phase;
    stopped_next          = stopped;
    st                    = ST_OK;
    hit                   = 1'b0;
    mem_we                = 1'b0;
    if (cmd_valid) begin
      unique case (cmd.kind)
        KIND_WRITE: begin
          if (stopped) begin
            st = ST_STOPPED;
          end else begin
            mem_we = 1'b1;
            write_index_next = (write_index == ADDR_W'(DEPTH - 1)) ? '0
                                                                   : write_index + 1'b1;
            fill_count_next = fill_inc;
            if (!read_index_valid) begin
              read_index_next       = '0;
              read_index_valid_next = 1'b1;
            end
            // full ring: flush everything
            if (fill_inc == FILL_W'(DEPTH)) begin
              write_index_next      = '0;
              read_index_next       = '0;
              read_index_valid_next = 1'b0;
              fill_count_next       = '0;
              drain_phase_next      = 1'b0;
              stopped_next          = 1'b0;
              st                    = ST_OVERFLOW;
            end
          end
        end
        KIND_READ: begin
          if (stopped) begin
            st = ST_STOPPED;
          end else if (!drain_phase &&
                       (CMP_W'(fill_count) < CMP_W'(prebuffer_count))) begin
            drain_phase_next = 1'b1;
            st = ST_NOT_READY;
          end else if (drain_phase && (fill_count == '0)) begin
            drain_phase_next = 1'b0;
            st = ST_NOT_READY;
          end else if (!read_index_valid) begin
            st = ST_NO_READ_POS;
          end else if (fill_count == '0) begin
            st = ST_NOT_READY;
          end else begin
            hit = 1'b1;
            fill_count_next = fill_count - 1'b1;
            read_index_next = (read_index == ADDR_W'(DEPTH - 1)) ? '0
                                                                 : read_index + 1'b1;
          end
        end
        KIND_STOP: begin
          stopped_next          = 1'b1;
          read_index_valid_next = 1'b0;
        end
        KIND_RESTART: begin
          write_index_next      = '0;
          read_index_next       = '0;
          read_index_valid_next = 1'b0;
          fill_count_next       = '0;
          drain_phase_next      = 1'b0;
          stopped_next          = 1'b0;
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_index] <= cmd.entry;
    end
    rdata <= mem[read_index];
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      read_index       <= '0;
      read_index_valid <= 1'b0;
      fill_count       <= '0;
      drain_phase      <= 1'b0;
      stopped          <= 1'b0;
      done             <= 1'b0;
      status           <= ST_OK;
      data_valid       <= 1'b0;
      fill_level       <= '0;
    end else begin
      write_index      <= write_index_next;
      read_index       <= read_index_next;
      read_index_valid <= read_index_valid_next;
      fill_count       <= fill_count_next;
      drain_phase      <= drain_phase_next;
      stopped          <= stopped_next;
      done             <= cmd_valid;
      status           <= st;
      data_valid       <= hit;
      fill_level       <= PREBUF_W'(fill_count_next);
    end
  end

  // result beat, entry fields zero unless an entry was read
  always_comb begin
    res.done       = done;
    res.status     = status;
    res.data_valid = data_valid;
    res.entry      = data_valid ? rdata : '0;
    res.fill_level = fill_level;
  end

endmodule

// ===== rtl/core/prebuffered_ring_fifo.sv =====
// top level of the prebuffered ring fifo
// One command beat (write, read, stop, restart) is taken per clock while busy is low, and
// each gives exactly one result beat. done goes high for a single cycle per result beat, after the
// command has passed the command queue slot and the back end's result register. The
// receiver has no way to stall, so done must be sampled every cycle. Sustained rate is one
// item per clock: the back end retires a command every cycle with a combinational ring
// update and a registered read of the 64-entry store, so the two-entry command queue does
// not fill and busy stays low. prebuffer_count is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while no result is pending, the block does not enforce it.
module prebuffered_ring_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] payload,
  input  logic [3:0]  payload_bytes,
  input  logic [31:0] stream_id,
  input  logic [31:0] user_tag,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  output logic        done,
  output logic [2:0]  status,
  output logic        data_valid,
  output logic [63:0] out_payload,
  output logic [3:0]  out_bytes,
  output logic [31:0] out_stream_id,
  output logic [31:0] out_user_tag,
  output logic [5:0]  fill_level
);
  import pfifo_pkg::*;

  logic                q_full;
  logic                push;
  cmd_t                push_cmd;
  logic                pop_valid;
  logic                pop;
  cmd_t                pop_cmd;
  res_t                res;
  logic [PREBUF_W-1:0] prebuffer_count;

  // prebuffer threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      prebuffer_count <= PREBUF_RESET;
    end else if (cfg_wr_en) begin
      prebuffer_count <= cfg_wr_data;
    end
  end

  pfifo_front u_front (
    .start         (start),
    .kind          (kind),
    .payload       (payload),
    .payload_bytes (payload_bytes),
    .stream_id     (stream_id),
    .user_tag      (user_tag),
    .q_full        (q_full),
    .busy          (busy),
    .push          (push),
    .cmd           (push_cmd)
  );

  pfifo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  pfifo_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (pop_valid),
    .cmd             (pop_cmd),
    .prebuffer_count (prebuffer_count),
    .pop             (pop),
    .res             (res)
  );

  // result ports
  assign done          = res.done;
  assign status        = res.status;
  assign data_valid    = res.data_valid;
  assign out_payload   = res.entry.payload;
  assign out_bytes     = res.entry.nbytes;
  assign out_stream_id = res.entry.stream_id;
  assign out_user_tag  = res.entry.user_tag;
  assign fill_level    = res.fill_level;

endmodule

// ===== verif/prebuffered_ring_fifo_tb.sv =====
// self-checking testbench of the prebuffered ring fifo with a built-in ring predictor
`timescale 1ns / 100ps

module prebuffered_ring_fifo_tb;
  import pfifo_pkg::*;

  typedef struct {
    status_t             status;
    logic                data_valid;
    entry_t              entry;
    logic [PREBUF_W-1:0] fill;
  } fifo_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_WRITE;
  logic [63:0] payload = '0;
  logic [3:0]  payload_bytes = '0;
  logic [31:0] stream_id = '0;
  logic [31:0] user_tag = '0;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        done;
  logic [2:0]  status;
  logic        data_valid;
  logic [63:0] out_payload;
  logic [3:0]  out_bytes;
  logic [31:0] out_stream_id;
  logic [31:0] out_user_tag;
  logic [5:0]  fill_level;

  // command beats still to send and results still owed by the block
  cmd_t         cmd_backlog[$];
  fifo_result_t results_due[$];
  cmd_t         cur_cmd;

  // predictor copy of the ring, its pointers and the gate level
  entry_t              ring [DEPTH];
  logic [ADDR_W-1:0]   wr_ptr, rd_ptr;
  logic                rd_ok;
  logic [FILL_W-1:0]   held;
  logic                draining, halted;
  logic [PREBUF_W-1:0] gate_level;

  // sender burst shaping
  logic idle_on = 1'b1;
  int   burst_left = 1;
  int   gap_left = 0;

  // run tallies
  int mismatches = 0;
  int n_beats = 0, n_served = 0, n_flush = 0, n_refused = 0, n_nopos = 0, n_rejected = 0;

  prebuffered_ring_fifo dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .payload       (payload),
    .payload_bytes (payload_bytes),
    .stream_id     (stream_id),
    .user_tag      (user_tag),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .done          (done),
    .status        (status),
    .data_valid    (data_valid),
    .out_payload   (out_payload),
    .out_bytes     (out_bytes),
    .out_stream_id (out_stream_id),
    .out_user_tag  (out_user_tag),
    .fill_level    (fill_level)
  );

  always #10 clk = ~clk;

  // empty the ring as a restart or an overflow does
  function automatic void clear_ring();
    wr_ptr   = '0;
    rd_ptr   = '0;
    rd_ok    = 1'b0;
    held     = '0;
    draining = 1'b0;
    halted   = 1'b0;
  endfunction

  // advance the predicted ring by one command and give its result
  function automatic fifo_result_t fifo_step(input cmd_t c);
    fifo_result_t r;
    logic [3:0]   nb;
    logic [63:0]  pay;
    r.status     = ST_OK;
    r.data_valid = 1'b0;
    r.entry      = '0;
    case (c.kind)
      KIND_WRITE: begin
        if (halted) begin
          r.status = ST_STOPPED;
        end else begin
          nb  = (c.entry.nbytes > MAX_BYTES) ? MAX_BYTES : c.entry.nbytes;
          pay = c.entry.payload;
          if (nb < MAX_BYTES) pay &= (64'd1 << (nb * 8)) - 64'd1;
          ring[wr_ptr] = '{payload: pay, nbytes: nb, stream_id: c.entry.stream_id,
                           user_tag: c.entry.user_tag};
          wr_ptr = (wr_ptr == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
          held++;
          if (!rd_ok) begin
            rd_ptr = '0;
            rd_ok  = 1'b1;
          end
          if (held >= DEPTH) begin
            clear_ring();
            r.status = ST_OVERFLOW;
          end
        end
      end
      KIND_READ: begin
        if (halted) begin
          r.status = ST_STOPPED;
        end else if (!draining && held < gate_level) begin
          draining = 1'b1;
          r.status = ST_NOT_READY;
        end else if (draining && held == 0) begin
          draining = 1'b0;
          r.status = ST_NOT_READY;
        end else if (!rd_ok) begin
          r.status = ST_NO_READ_POS;
        end else if (held == 0) begin
          r.status = ST_NOT_READY;
        end else begin
          r.data_valid = 1'b1;
          r.entry      = ring[rd_ptr];
          held--;
          rd_ptr = (rd_ptr == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
        end
      end
      KIND_STOP: begin
        halted = 1'b1;
        rd_ok  = 1'b0;
      end
      default: clear_ring();
    endcase
    r.fill = held[PREBUF_W-1:0];
    return r;
  endfunction

  function automatic cmd_t make_cmd(input kind_t k, input logic [63:0] p,
                                    input logic [3:0] nb, input logic [31:0] sid,
                                    input logic [31:0] tag);
    cmd_t c;
    c.kind            = k;
    c.entry.payload   = p;
    c.entry.nbytes    = nb;
    c.entry.stream_id = sid;
    c.entry.user_tag  = tag;
    return c;
  endfunction

  // random content, byte count now and then above the maximum
  function automatic cmd_t rand_cmd(input kind_t k);
    logic [3:0] nb;
    nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    return make_cmd(k, {$urandom, $urandom}, nb, $urandom, $urandom);
  endfunction

  // mostly write and read runs, some long enough to overflow, plus stop and noise
  task automatic queue_random_phase(input int n_items);
    int    added;
    int    pick;
    int    run;
    int    sel;
    kind_t k;
    added = 0;
    while (added < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
        repeat (run) cmd_backlog.push_back(rand_cmd(KIND_WRITE));
      end else if (pick < 78) begin
        run = $urandom_range(1, 24);
        repeat (run) cmd_backlog.push_back(rand_cmd(KIND_READ));
      end else if (pick < 90) begin
        run = $urandom_range(1, 10);
        repeat (run) begin
          sel = $urandom_range(0, 9);
          k = (sel < 4) ? KIND_WRITE : (sel < 8) ? KIND_READ : (sel == 8) ? KIND_STOP
                                                                          : KIND_RESTART;
          cmd_backlog.push_back(rand_cmd(k));
        end
      end else if (pick < 96) begin
        run = $urandom_range(0, 6);
        cmd_backlog.push_back(rand_cmd(KIND_STOP));
        repeat (run) cmd_backlog.push_back(rand_cmd($urandom_range(0, 1) ? KIND_READ
                                                                        : KIND_WRITE));
        cmd_backlog.push_back(rand_cmd(KIND_RESTART));
        run += 2;
      end else begin
        run = 1;
        cmd_backlog.push_back(rand_cmd(KIND_RESTART));
      end
      added += run;
    end
  endtask

  // wait until every beat is sent and every result has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || results_due.size() != 0);
  endtask

  task automatic set_gate_level(input logic [5:0] lvl);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lvl;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    gate_level = lvl;
  endtask

  // driver: present beats from the backlog in bursts, predict each accepted one
  always @(posedge clk) begin : drive_beats
    logic go;
    go = start;
    if (rst) begin
      go = 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        results_due.push_back(fifo_step(cur_cmd));
        n_beats++;
      end
      if (idle_on && gap_left > 0) begin
        gap_left--;
        go = 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        cur_cmd       = cmd_backlog.pop_front();
        kind          <= cur_cmd.kind;
        payload       <= cur_cmd.entry.payload;
        payload_bytes <= cur_cmd.entry.nbytes;
        stream_id     <= cur_cmd.entry.stream_id;
        user_tag      <= cur_cmd.entry.user_tag;
        go = 1'b1;
        if (idle_on) begin
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end else begin
        go = 1'b0;
      end
    end
    start <= go;
  end

  // monitor: every done beat is checked against the oldest owed result
  always @(posedge clk) begin : check_beats
    fifo_result_t want;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing owed", $realtime);
      end else begin
        want = results_due.pop_front();
        if (status !== want.status || data_valid !== want.data_valid ||
            out_payload !== want.entry.payload || out_bytes !== want.entry.nbytes ||
            out_stream_id !== want.entry.stream_id ||
            out_user_tag !== want.entry.user_tag || fill_level !== want.fill) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp st %0d dv %0b pay %h nb %0d sid %h tag %h fill %0d", $realtime,
                     want.status, want.data_valid, want.entry.payload, want.entry.nbytes,
                     want.entry.stream_id, want.entry.user_tag, want.fill,
                     "\n            got st %0d dv %0b pay %h nb %0d sid %h tag %h fill %0d",
                     status, data_valid, out_payload, out_bytes, out_stream_id,
                     out_user_tag, fill_level);
        end
        case (want.status)
          ST_OVERFLOW:    n_flush++;
          ST_NOT_READY:   n_refused++;
          ST_NO_READ_POS: n_nopos++;
          ST_STOPPED:     n_rejected++;
          default:        if (want.data_valid) n_served++;
        endcase
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [5:0] levels [7];
    clear_ring();
    gate_level = PREBUF_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // gate at its reset level: refusals, byte trimming, draining, stop and restart
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, '1, 4'd0, '1, '1));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, '1, 4'd8, '1, '1));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, {$urandom, $urandom}, 4'd15, '0, '1));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, {$urandom, $urandom}, 4'd3, '1, '0));
    repeat (5) cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_STOP, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, '1, 4'd8, '1, '1));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_STOP, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_RESTART, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, {$urandom, $urandom}, 4'd1, $urandom, $urandom));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_RESTART, '0, 4'd0, '0, '0));

    // gate level zero: no read position, then an empty ring that still passes the gate
    set_gate_level(6'd0);
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_WRITE, {$urandom, $urandom}, 4'd7, $urandom, $urandom));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_READ, '0, 4'd0, '0, '0));
    cmd_backlog.push_back(make_cmd(KIND_RESTART, '0, 4'd0, '0, '0));

    // random phases over several gate levels, one without sender gaps
    levels[0] = 6'd63;
    levels[1] = 6'd1;
    levels[2] = 6'd0;
    levels[3] = 6'($urandom_range(3, 62));
    levels[4] = 6'($urandom_range(3, 62));
    levels[5] = 6'($urandom_range(3, 62));
    levels[6] = PREBUF_RESET;
    for (int i = 0; i < 7; i++) begin
      set_gate_level(levels[i]);
      idle_on = (i != 2);
      queue_random_phase(215);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d command beats checked, %0d reads returned an entry, %0d overflow flushes",
             n_beats, n_served, n_flush);
    $display("%0d not-ready refusals, %0d without read position, %0d rejected when stopped",
             n_refused, n_nopos, n_rejected);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pfifo_pkg.sv
rtl/core/pfifo_front.sv
rtl/core/pfifo_queue.sv
rtl/core/pfifo_back.sv
rtl/core/prebuffered_ring_fifo.sv
verif/prebuffered_ring_fifo_tb.sv
